// ===== rtl/sklp_pkg.sv =====
// Shared types and constants for the string-key linear-probe table.
// No dependencies; imported by every module of the block but the queue.
`default_nettype none

package sklp_pkg;

  // Polynomial hash modulus and byte mapping constants, 30-bit field arithmetic
  localparam int unsigned  HASH_W   = 30;
  localparam logic [29:0]  HASH_MOD = 30'd1000000009;
  localparam logic [7:0]   CHAR_BIAS = 8'd96;
  localparam logic [7:0]   UPPER_A   = 8'h41;
  localparam logic [7:0]   UPPER_Z   = 8'h5A;
  localparam logic [7:0]   CASE_OFS  = 8'd32;

  // Serial modular multiply walks the 30 multiplier bits MSB first
  localparam logic [4:0]   MUL_TOP_STEP = 5'd29;
  // Base 31 = 32 - 1: five doublings of the power run in the first five steps
  localparam logic [4:0]   PW_DBL_LOW   = 5'd25;
  // Slot reduction: reciprocal multiply, then multiply back and correct
  localparam logic [4:0]   MOD_TOP_STEP = 5'd1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_ACC  = 5'b00100,
    F_MOD  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_e;

  typedef enum logic [4:0] {
    B_CLR  = 5'b00001,
    B_IDLE = 5'b00010,
    B_RD   = 5'b00100,
    B_CMP  = 5'b01000,
    B_EMIT = 5'b10000
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/sklp_in_if.sv =====
// Input channel: one key byte per beat with operation, last flag and payload.
// No dependencies.
`default_nettype none

interface sklp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  char_code;
  logic        last_char;
  logic [15:0] record_id;

  modport source (output valid, func, char_code, last_char, record_id, input ready);
  modport sink   (input valid, func, char_code, last_char, record_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/sklp_out_if.sv =====
// Result channel: status, slot and record of one finished operation per beat.
// No dependencies.
`default_nettype none

interface sklp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [10:0] slot;
  logic [15:0] found_record;

  modport source (output valid, status, slot, found_record, input ready);
  modport sink   (input valid, status, slot, found_record, output ready);
endinterface

`default_nettype wire

// ===== rtl/sklp_queue.sv =====
// Two-entry command queue between the key front end and the probe engine.
// Generic width; no package dependencies.
`default_nettype none

module sklp_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output logic         empty_o
);

  logic [W-1:0] data_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = data_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i && !empty_o) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sklp_front.sv =====
// Front end: accepts key bytes, keeps the key prefix and its polynomial hash,
// and queues one probe command per key. Uses sklp_pkg and sklp_in_if.
`default_nettype none

module sklp_front import sklp_pkg::*; #(
  parameter int unsigned MAX_KEY    = 20,
  parameter int unsigned TABLE_SIZE = 2048,
  localparam int unsigned LENW = $clog2(MAX_KEY + 1),
  localparam int unsigned IDXW = $clog2(TABLE_SIZE),
  localparam int unsigned CMDW = 1 + 16 + IDXW + LENW + MAX_KEY * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enable_i,
  sklp_in_if.sink         in_i,
  output logic            push_o,
  output logic [CMDW-1:0] push_data_o,
  input  logic            full_i
);

  localparam logic [30:0] MOD31 = {1'b0, HASH_MOD};
  // Floor reciprocal of the table size; the quotient estimate is at most one low
  localparam int unsigned RSH   = HASH_W + IDXW;
  localparam logic [30:0] RECIP = 31'((64'd1 << RSH) / 64'(TABLE_SIZE));

  front_state_e          state_q, state_d;
  logic [LENW-1:0]       len_q, len_d;
  logic [MAX_KEY*8-1:0]  buf_q, buf_d;
  logic [29:0]           hash_q, hash_d, pow_q, pow_d;
  logic [29:0]           term_q, term_d, acc_q, acc_d, pw_q, pw_d;
  logic [4:0]            step_q, step_d;
  logic [IDXW-1:0]       r_q, r_d;
  logic                  last_q, last_d, func_q, func_d;
  logic [15:0]           rec_q, rec_d;
  logic                  accept;
  logic [30:0]           dbl_acc, sum_acc, dbl_pw, hsum, pdiff;
  logic [60:0]           prod;
  logic [29:0]           qd, rdiff, rcor;

  // Map a raw byte to its reduced hash digit (lowercase, minus bias)
  function automatic logic [29:0] char_term(input logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_OFS : c;
    if (lc >= CHAR_BIAS) return 30'(lc - CHAR_BIAS);
    else                 return HASH_MOD - 30'(CHAR_BIAS - lc);
  endfunction

  assign in_i.ready  = enable_i && (state_q == F_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_data_o = {func_q, rec_q, r_q, len_q, buf_q};

  // One modular multiply step, one power doubling and the final merges
  always_comb begin
    dbl_acc = {acc_q, 1'b0};
    if (dbl_acc >= MOD31) dbl_acc = dbl_acc - MOD31;
    sum_acc = dbl_acc + (term_q[step_q] ? {1'b0, pow_q} : 31'd0);
    if (sum_acc >= MOD31) sum_acc = sum_acc - MOD31;
    dbl_pw = {pw_q, 1'b0};
    if (dbl_pw >= MOD31) dbl_pw = dbl_pw - MOD31;
    hsum = {1'b0, hash_q} + {1'b0, acc_q};
    if (hsum >= MOD31) hsum = hsum - MOD31;
    pdiff = (pw_q >= pow_q) ? {1'b0, pw_q} - {1'b0, pow_q}
                            : {1'b0, pw_q} + MOD31 - {1'b0, pow_q};
    // Slot index: estimate the quotient, multiply back, correct once
    prod  = {31'd0, hash_q} * {30'd0, RECIP};
    qd    = term_q * 30'(TABLE_SIZE);
    rdiff = hash_q - qd;
    rcor  = (rdiff >= 30'(TABLE_SIZE)) ? rdiff - 30'(TABLE_SIZE) : rdiff;
  end

  // Sequence byte intake, hashing, slot reduction and command push
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    buf_d   = buf_q;
    hash_d  = hash_q;
    pow_d   = pow_q;
    term_d  = term_q;
    acc_d   = acc_q;
    pw_d    = pw_q;
    step_d  = step_q;
    r_d     = r_q;
    last_d  = last_q;
    func_d  = func_q;
    rec_d   = rec_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          last_d = in_i.last_char;
          func_d = in_i.func;
          rec_d  = in_i.record_id;
          step_d = MUL_TOP_STEP;
          r_d    = '0;
          if (len_q < LENW'(MAX_KEY)) begin
            term_d = char_term(in_i.char_code);
            for (int i = 0; i < MAX_KEY; i++) begin
              if (len_q == LENW'(i)) buf_d[i*8 +: 8] = in_i.char_code;
            end
            len_d   = len_q + LENW'(1);
            acc_d   = '0;
            pw_d    = pow_q;
            state_d = F_MUL;
          end else if (in_i.last_char) begin
            step_d  = MOD_TOP_STEP;
            state_d = F_MOD;
          end
        end
      end
      F_MUL: begin
        acc_d = sum_acc[29:0];
        if (step_q >= PW_DBL_LOW) pw_d = dbl_pw[29:0];
        if (step_q == '0) state_d = F_ACC;
        else              step_d  = step_q - 5'd1;
      end
      F_ACC: begin
        hash_d  = hsum[29:0];
        pow_d   = pdiff[29:0];
        step_d  = MOD_TOP_STEP;
        r_d     = '0;
        state_d = last_q ? F_MOD : F_IDLE;
      end
      F_MOD: begin
        if (step_q != '0) begin
          term_d = 30'(prod >> RSH);
          step_d = step_q - 5'd1;
        end else begin
          r_d     = rcor[IDXW-1:0];
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          len_d   = '0;
          hash_d  = '0;
          pow_d   = 30'd1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      len_q   <= '0;
      hash_q  <= '0;
      pow_q   <= 30'd1;
      step_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      hash_q  <= hash_d;
      pow_q   <= pow_d;
      step_q  <= step_d;
      last_q  <= last_d;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    term_q <= term_d;
    acc_q  <= acc_d;
    pw_q   <= pw_d;
    r_q    <= r_d;
    func_q <= func_d;
    rec_q  <= rec_d;
  end

endmodule

`default_nettype wire

// ===== rtl/sklp_back.sv =====
// Probe engine: clears the slot memory after reset, then walks slots for
// insert and search commands and drives the result register.
// Uses sklp_pkg and sklp_out_if.
`default_nettype none

module sklp_back import sklp_pkg::*; #(
  parameter int unsigned MAX_KEY    = 20,
  parameter int unsigned TABLE_SIZE = 2048,
  localparam int unsigned LENW = $clog2(MAX_KEY + 1),
  localparam int unsigned IDXW = $clog2(TABLE_SIZE),
  localparam int unsigned CMDW = 1 + 16 + IDXW + LENW + MAX_KEY * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            clr_done_o,
  input  logic            empty_i,
  input  logic [CMDW-1:0] cmd_i,
  output logic            pop_o,
  sklp_out_if.source      out_o
);

  localparam int unsigned ROWW = LENW + 16 + MAX_KEY * 8;

  back_state_e          state_q, state_d;
  logic                 func_q, func_d;
  logic [15:0]          rec_q, rec_d;
  logic [LENW-1:0]      klen_q, klen_d;
  logic [MAX_KEY*8-1:0] kbuf_q, kbuf_d;
  logic [IDXW-1:0]      idx_q, idx_d, idx_inc, cmd_start;
  logic [IDXW:0]        n_q, n_d;
  status_e              res_status_q, res_status_d, out_status_q;
  logic [IDXW-1:0]      res_slot_q, res_slot_d;
  logic [15:0]          res_rec_q, res_rec_d, out_rec_q;
  logic [10:0]          out_slot_q;
  logic                 out_valid_q, out_valid_d, load_out;
  logic                 we, re, match;
  logic [ROWW-1:0]      wdata, rdata_q;
  logic [ROWW-1:0]      mem_q [TABLE_SIZE];
  logic [LENW-1:0]      row_len;
  logic [15:0]          row_rec;
  logic [MAX_KEY*8-1:0] row_chars;
  logic                 cmd_func;
  logic [15:0]          cmd_rec;
  logic [LENW-1:0]      cmd_len;
  logic [MAX_KEY*8-1:0] cmd_buf;

  assign {cmd_func, cmd_rec, cmd_start, cmd_len, cmd_buf} = cmd_i;
  assign {row_len, row_rec, row_chars} = rdata_q;

  assign clr_done_o = (state_q != B_CLR);
  assign idx_inc    = (idx_q == IDXW'(TABLE_SIZE - 1)) ? '0 : idx_q + IDXW'(1);
  assign load_out   = (state_q == B_EMIT) && (!out_valid_q || out_o.ready);

  // Compare the stored key against the command key over its length
  always_comb begin
    match = (row_len == klen_q);
    for (int i = 0; i < MAX_KEY; i++) begin
      if (LENW'(i) < klen_q && row_chars[i*8 +: 8] != kbuf_q[i*8 +: 8]) match = 1'b0;
    end
  end

  // Sequence clearing pass and slot probing
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    rec_d        = rec_q;
    klen_d       = klen_q;
    kbuf_d       = kbuf_q;
    idx_d        = idx_q;
    n_d          = n_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_rec_d    = res_rec_q;
    pop_o        = 1'b0;
    we           = 1'b0;
    re           = 1'b0;
    wdata        = '0;
    case (state_q)
      B_CLR: begin
        we = 1'b1;
        idx_d = idx_inc;
        if (idx_q == IDXW'(TABLE_SIZE - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          func_d  = cmd_func;
          rec_d   = cmd_rec;
          klen_d  = cmd_len;
          kbuf_d  = cmd_buf;
          idx_d   = cmd_start;
          n_d     = '0;
          state_d = B_RD;
        end
      end
      B_RD: begin
        if (n_q == (IDXW+1)'(TABLE_SIZE)) begin
          res_status_d = (func_q == FUNC_SEARCH) ? ST_NOT_FOUND : ST_FULL;
          res_slot_d   = '0;
          res_rec_d    = '0;
          state_d      = B_EMIT;
        end else begin
          re      = 1'b1;
          state_d = B_CMP;
        end
      end
      B_CMP: begin
        if (func_q == FUNC_INSERT && row_len == '0) begin
          we           = 1'b1;
          wdata        = {klen_q, rec_q, kbuf_q};
          res_status_d = ST_INSERTED;
          res_slot_d   = idx_q;
          res_rec_d    = rec_q;
          state_d      = B_EMIT;
        end else if (func_q == FUNC_SEARCH && row_len == '0) begin
          res_status_d = ST_NOT_FOUND;
          res_slot_d   = '0;
          res_rec_d    = '0;
          state_d      = B_EMIT;
        end else if (func_q == FUNC_SEARCH && match) begin
          res_status_d = ST_FOUND;
          res_slot_d   = idx_q;
          res_rec_d    = row_rec;
          state_d      = B_EMIT;
        end else begin
          idx_d   = idx_inc;
          n_d     = n_q + (IDXW+1)'(1);
          state_d = B_RD;
        end
      end
      B_EMIT: begin
        if (load_out) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[idx_q] <= wdata;
    if (re) rdata_q <= mem_q[idx_q];
  end

  // Drop the result once taken, load a new one when free
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      idx_q       <= '0;
      n_q         <= '0;
      func_q      <= FUNC_INSERT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      func_q      <= func_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold command and result payload
  always_ff @(posedge clk_i) begin
    rec_q        <= rec_d;
    klen_q       <= klen_d;
    kbuf_q       <= kbuf_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_rec_q    <= res_rec_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= 11'(res_slot_q);
      out_rec_q    <= res_rec_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.slot         = out_slot_q;
  assign out_o.found_record = out_rec_q;

endmodule

`default_nettype wire

// ===== rtl/string_key_linear_probe_table_top.sv =====
// Top level of the string-key linear-probe table: front end, command queue
// and probe engine. Uses sklp_pkg, sklp_in_if, sklp_out_if and the sklp modules.
//
// Usage: send a key one byte per beat on in_i, with last_char set on the
// final byte; func (0 insert, 1 search) and record_id are taken from that
// beat. Uppercase ASCII folds to lowercase for the hash; only the first
// MAX_KEY bytes count. Each last byte yields one beat on out_o with status
// (inserted, found, not found, full), slot and record.
// Flow: a byte inside the key prefix runs a 30-step serial modular
// multiply plus an accumulate; a byte past the prefix is accepted unhashed.
// A last byte adds slot reduction (reciprocal multiply, then multiply back
// and correct) and a push into the two-entry command queue, so the next key
// streams in while the probe runs.
// The probe engine reads and then compares each visited slot, up to
// TABLE_SIZE slots, and then posts the result.
// Reset: in_i.ready stays low while every slot is marked empty. A stalled
// out_o holds its beat; the engine waits with the next result, the queue
// fills and then in_i.ready drops.
`default_nettype none

module string_key_linear_probe_table_top import sklp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 2048,
  parameter int unsigned MAX_KEY    = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sklp_in_if.sink    in_i,
  sklp_out_if.source out_o
);

  localparam int unsigned LENW = $clog2(MAX_KEY + 1);
  localparam int unsigned IDXW = $clog2(TABLE_SIZE);
  localparam int unsigned CMDW = 1 + 16 + IDXW + LENW + MAX_KEY * 8;

  logic            clr_done, push, full, pop, empty;
  logic [CMDW-1:0] push_data, pop_data;

  sklp_front #(.MAX_KEY(MAX_KEY), .TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (clr_done),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  sklp_queue #(.W(CMDW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  sklp_back #(.MAX_KEY(MAX_KEY), .TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_done_o (clr_done),
    .empty_i    (empty),
    .cmd_i      (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sklp_checker.sv =====
// Port-level checks for the string-key linear-probe table, bound to the top.
// Uses sklp_pkg for the status codes.
`default_nettype none

module sklp_checker import sklp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [10:0] slot_i,
  input logic [15:0] found_record_i
);

  // A stalled result beat stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(slot_i) && $stable(found_record_i))
    else $error("result beat changed while stalled");

  // Miss and full results carry no slot and no record
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_NOT_FOUND || status_i == ST_FULL)
      |-> slot_i == '0 && found_record_i == '0)
    else $error("miss or full result with nonzero fields");

  // No intake while in reset or in the first cycle after it (clearing pass)
  a_clear_blocks: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("input ready during reset or slot clearing");

endmodule

bind string_key_linear_probe_table_top sklp_checker u_sklp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .slot_i         (out_o.slot),
  .found_record_i (out_o.found_record)
);

`default_nettype wire

// ===== test/sklp_result_checker.sv =====
// Result checker for the string-key linear-probe table: watches both channels,
// keeps its own copy of the slot table and compares every result beat.
// Depends on sklp_pkg, sklp_in_if and sklp_out_if.
`default_nettype none

module sklp_result_checker import sklp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 2048,
  parameter int unsigned MAX_KEY    = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sklp_in_if.sink    in_w,
  sklp_out_if.sink   out_w,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_seen_o
);

  localparam longint unsigned MODULUS = 64'd1000000009;

  typedef struct packed {
    status_e     status;
    logic [10:0] slot;
    logic [15:0] found_record;
  } lookup_result_t;

  // Predicted copy of the block's state
  logic [7:0]  cur_key [MAX_KEY];
  int unsigned cur_len;
  longint unsigned cur_hash, cur_pow;
  logic [7:0]  tbl_chars [TABLE_SIZE][MAX_KEY];
  int unsigned tbl_len [TABLE_SIZE];
  logic [15:0] tbl_rec [TABLE_SIZE];
  lookup_result_t expected_results [$];

  function automatic bit key_matches(int unsigned s);
    if (tbl_len[s] != cur_len) return 1'b0;
    for (int unsigned i = 0; i < cur_len; i++)
      if (tbl_chars[s][i] != cur_key[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Fold one key byte into the hash and, on the last byte, run the probe
  task automatic absorb_byte(input logic fn, input logic [7:0] c, input logic lst,
                             input logic [15:0] rec);
    longint unsigned lc, term;
    int unsigned idx;
    lookup_result_t r;
    if (cur_len < MAX_KEY) begin
      lc = (c >= UPPER_A && c <= UPPER_Z) ? c + 32 : c;
      term = (lc + MODULUS - 96) % MODULUS;
      term = term * cur_pow % MODULUS;
      cur_hash = (cur_hash + term) % MODULUS;
      cur_pow = cur_pow * 31 % MODULUS;
      cur_key[cur_len] = c;
      cur_len++;
    end
    if (!lst) return;
    idx = 32'(cur_hash % TABLE_SIZE);
    r = '{ST_NOT_FOUND, 11'd0, 16'd0};
    if (fn == FUNC_INSERT) begin
      r.status = ST_FULL;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (tbl_len[idx] == 0) begin
          for (int unsigned i = 0; i < cur_len; i++) tbl_chars[idx][i] = cur_key[i];
          tbl_len[idx] = cur_len;
          tbl_rec[idx] = rec;
          r = '{ST_INSERTED, idx[10:0], rec};
          break;
        end
        idx = (idx + 1) % TABLE_SIZE;
      end
    end else begin
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (tbl_len[idx] == 0) break;
        if (key_matches(idx)) begin
          r = '{ST_FOUND, idx[10:0], tbl_rec[idx]};
          break;
        end
        idx = (idx + 1) % TABLE_SIZE;
      end
    end
    expected_results.insert(expected_results.size(), r);
    cur_len = 0;
    cur_hash = 0;
    cur_pow = 1;
  endtask

  // Sample both channels at the edge, predict and compare
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      results_seen_o = 0;
      cur_len = 0;
      cur_hash = 0;
      cur_pow = 1;
      for (int i = 0; i < TABLE_SIZE; i++) tbl_len[i] = 0;
      expected_results.delete();
    end else begin
      if (in_w.valid && in_w.ready)
        absorb_byte(in_w.func, in_w.char_code, in_w.last_char, in_w.record_id);
      if (out_w.valid && out_w.ready) begin
        results_seen_o++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d slot=%0d record=%0d",
                   $time, out_w.status, out_w.slot, out_w.found_record);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_w.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_w.status);
            fail_count_o++;
          end
          if (out_w.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_w.slot);
            fail_count_o++;
          end
          if (out_w.found_record !== want.found_record) begin
            $display("%0t: record expected %0d actual %0d", $time, want.found_record,
                     out_w.found_record);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

`default_nettype wire

// ===== test/string_key_linear_probe_table_top_tb.sv =====
// Testbench top for the string-key linear-probe table: drives key bytes,
// stalls the result side and gives the verdict. Uses sklp_result_checker.
`default_nettype none

module string_key_linear_probe_table_top_tb;
  import sklp_pkg::*;

  localparam int unsigned TABLE_SIZE = 2048;
  localparam int unsigned MAX_KEY    = 20;
  localparam int          STALL_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count, pending, results_seen;
  int   bytes_sent = 0, keys_sent = 0;
  bit   long_hold = 1'b0;
  int   idle_cycles = 0;
  int   rx_wait;

  sklp_in_if  in_ch ();
  sklp_out_if out_ch ();

  string_key_linear_probe_table_top #(.TABLE_SIZE(TABLE_SIZE), .MAX_KEY(MAX_KEY)) dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  sklp_result_checker #(.TABLE_SIZE(TABLE_SIZE), .MAX_KEY(MAX_KEY)) checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_ch.sink), .out_w(out_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always #5 clk_i = ~clk_i;

  // Pool of reused keys so searches hit stored entries
  logic [7:0] key_pool [16][$];

  // Send one byte beat after a random gap; valid drops only during a gap
  task automatic send_byte(input logic fn, input logic [7:0] c, input logic lst,
                           input logic [15:0] rec);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.char_code <= c;
    in_ch.last_char <= lst;
    in_ch.record_id <= rec;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_key(input logic fn, input logic [7:0] k[$], input logic [15:0] rec);
    for (int i = 0; i < k.size(); i++)
      send_byte(fn, k[i], i == k.size() - 1, rec);
    keys_sent++;
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 3))
      0: return 8'(($urandom_range(0, 25)) + 8'h61);
      1: return 8'(($urandom_range(0, 25)) + 8'h41);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: randomly withhold ready before each beat, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    int w;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= $urandom_range(0, 7);
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = $urandom_range(0, 7);
      rx_wait      <= w;
      out_ch.ready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (2500) @(posedge clk_i);
    wait (keys_sent > 30);
    long_hold = 1'b1;
    repeat (8000) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // Watchdog: count cycles with no beat on either channel outside the long hold-off
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || long_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] k[$];
    int sel;
    int len;
    rst_ni <= 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_INSERT;
    in_ch.char_code = 8'd0;
    in_ch.last_char = 1'b0;
    in_ch.record_id = 16'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, case folding, long keys, both operations
    k = '{8'h00};                 send_key(FUNC_SEARCH, k, 16'hFFFF);
    k = '{8'h00};                 send_key(FUNC_INSERT, k, 16'h0000);
    k = '{8'hFF};                 send_key(FUNC_INSERT, k, 16'hFFFF);
    k = '{8'hFF};                 send_key(FUNC_SEARCH, k, 16'h0000);
    k = '{8'h41, 8'h5A};          send_key(FUNC_INSERT, k, 16'h1234);
    k = '{8'h61, 8'h7A};          send_key(FUNC_SEARCH, k, 16'h0);
    k = '{8'h41, 8'h5A};          send_key(FUNC_SEARCH, k, 16'h0);
    k = '{8'h41, 8'h5A};          send_key(FUNC_INSERT, k, 16'hABCD);
    k = {};
    for (int i = 0; i < 25; i++) k.insert(k.size(), 8'h61 + 8'(i % 26));
    send_key(FUNC_INSERT, k, 16'h5555);
    k[24] = 8'h01;                send_key(FUNC_SEARCH, k, 16'h0);
    k = k[0:18];                  send_key(FUNC_SEARCH, k, 16'h0);

    for (int p = 0; p < 16; p++) begin
      key_pool[p] = {};
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) key_pool[p].insert(key_pool[p].size(), rand_char());
    end

    // Random: mostly pooled keys so searches hit, some fresh ones
    while (bytes_sent < 1300) begin
      sel = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) begin
        k = {};
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) k.insert(k.size(), rand_char());
      end else begin
        k = key_pool[sel];
      end
      send_key(func_e'($urandom_range(0, 1)), k, 16'($urandom));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (8000) @(posedge clk_i);
    $display("Sent %0d key bytes in %0d keys; checked %0d result beats",
             bytes_sent, keys_sent, results_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/sklp_pkg.sv
rtl/sklp_in_if.sv
rtl/sklp_out_if.sv
rtl/sklp_queue.sv
rtl/sklp_front.sv
rtl/sklp_back.sv
rtl/string_key_linear_probe_table_top.sv
rtl/sklp_checker.sv
test/sklp_result_checker.sv
test/string_key_linear_probe_table_top_tb.sv
